// ===== rtl/qe_pkg.sv =====
package qe_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int SQRT_CELLS    = 29;
	localparam int HOLD_LEN      = SQRT_CELLS + 1;
	localparam int SIDE_LEN      = HOLD_LEN + 1 + CORDIC_STAGES;
	localparam int LAST          = 34 + CORDIC_STAGES;

	localparam int CW = 37;
	localparam int ZW = 29;
	localparam int SW = 58;

	localparam logic signed [33:0] ONE_Q28    = 34'sd268435456;
	localparam logic signed [32:0] POLE_LIMIT = 33'sd133949292;
	localparam logic signed [ZW-1:0] PI_Q24   = 29'sd52707179;
	localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
	localparam logic signed [16:0] LIM_POLE   = 17'sd51472;
	localparam logic signed [16:0] LIM_REG    = 17'sd25736;

	typedef enum logic [1:0] {
		POLE_NONE  = 2'd0,
		POLE_NORTH = 2'd1,
		POLE_SOUTH = 2'd2
	} pole_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic [SW-1:0] v;
		logic [SW-1:0] r;
	} sqrt_t;

	typedef struct packed {
		pole_t pole;
		logic  zero_h;
		logic  zero_b;
	} side_t;

	// arctangent of 2^-i in Q.24 radians
	function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
		logic signed [ZW-1:0] a;
		unique case (i)
			5'd0: a = 29'sd13176795;
			5'd1: a = 29'sd7778716;
			5'd2: a = 29'sd4110060;
			5'd3: a = 29'sd2086331;
			5'd4: a = 29'sd1047214;
			5'd5: a = 29'sd524117;
			5'd6: a = 29'sd262123;
			5'd7: a = 29'sd131069;
			5'd8: a = 29'sd65536;
			5'd9: a = 29'sd32768;
			5'd10: a = 29'sd16384;
			5'd11: a = 29'sd8192;
			5'd12: a = 29'sd4096;
			5'd13: a = 29'sd2048;
			5'd14: a = 29'sd1024;
			5'd15: a = 29'sd512;
			5'd16: a = 29'sd256;
			5'd17: a = 29'sd128;
			5'd18: a = 29'sd64;
			5'd19: a = 29'sd32;
			5'd20: a = 29'sd16;
			5'd21: a = 29'sd8;
			5'd22: a = 29'sd4;
			5'd23: a = 29'sd2;
			default: a = '0;
		endcase
		return a;
	endfunction

	// fold left half plane into right half plane
	function automatic cordic_t cordic_pre(input logic signed [CW-1:0] y,
			input logic signed [CW-1:0] x);
		cordic_t c;
		c.x = x;
		c.y = y;
		c.z = '0;
		if (x < 0) begin
			c.z = (y >= 0) ? PI_Q24 : -PI_Q24;
			c.x = -x;
			c.y = -y;
		end
		return c;
	endfunction

	// Q.24 to Q3.13, round half up, clamp to +-lim
	function automatic logic signed [16:0] to_q13(input logic signed [30:0] v,
			input logic signed [16:0] lim);
		logic signed [31:0] t;
		logic signed [31:0] l;
		t = (32'(v) + 32'sd1024) >>> 11;
		l = 32'(lim);
		if (t > l) t = l;
		if (t < -l) t = -l;
		return t[16:0];
	endfunction

endpackage

// ===== rtl/quaternion_to_euler_angles.sv =====
// Throughput: one quaternion per cycle; the whole pipeline advances together
// and holds while the output register is full and not taken.
// The depth is set by the 29 root cells and the arcsine CORDIC row after them.
// Reset (arst_n low, asynchronous) clears all valid bits; data is not reset.
module quaternion_to_euler_angles
	import qe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] heading,
	output logic signed [14:0] attitude,
	output logic signed [15:0] bank,
	output logic [1:0]         pole_case
);

	logic adv;
	logic valid_q [1:LAST];

	logic signed [15:0] x_s1, w_s1;
	logic signed [31:0] xy_s1, zw_s1, yw_s1, xz_s1, xw_s1, yz_s1, xx_s1, yy_s1, zz_s1;

	logic signed [CW-1:0] hy_s2, hx_s2, by_s2, bx_s2;
	logic signed [29:0]   s_s2;
	pole_t                pole_s2;

	logic signed [32:0] test;
	logic signed [34:0] s_full;
	logic signed [33:0] hn, hd, bn, bd;
	pole_t              pole_c;

	logic [SW-1:0]      rad_s3;
	logic signed [59:0] ssq;

	cordic_t ch [0:CORDIC_STAGES];
	cordic_t cb [0:CORDIC_STAGES];
	cordic_t ca [0:CORDIC_STAGES];
	sqrt_t   sq [0:SQRT_CELLS];

	side_t                side_q [0:SIDE_LEN-1];
	logic signed [29:0]   sdel_q [0:HOLD_LEN-1];
	logic signed [ZW-1:0] zh_q   [0:HOLD_LEN-1];
	logic signed [ZW-1:0] zb_q   [0:HOLD_LEN-1];

	side_t                side_o;
	logic signed [ZW-1:0] zh_o, zb_o;
	logic signed [30:0]   hv;
	logic signed [16:0]   head_c, att_c, bank_c;

	// advance whenever the output register is free or being taken
	assign adv = !valid_q[LAST] || out_ready;
	assign in_ready = adv;
	assign out_valid = valid_q[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++) valid_q[i] <= 1'b0;
		end else if (adv) begin
			valid_q[1] <= in_valid;
			for (int i = 2; i <= LAST; i++) valid_q[i] <= valid_q[i-1];
		end
	end

	// stage 1: all pairwise products
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= quat_x;
			w_s1 <= quat_w;
			xy_s1 <= quat_x * quat_y;
			zw_s1 <= quat_z * quat_w;
			yw_s1 <= quat_y * quat_w;
			xz_s1 <= quat_x * quat_z;
			xw_s1 <= quat_x * quat_w;
			yz_s1 <= quat_y * quat_z;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
		end
	end

	// stage 2: pole test, atan2 operands, clamped arcsine argument
	always_comb begin
		test = 33'(xy_s1) + 33'(zw_s1);
		s_full = 35'(test) <<< 1;
		hn = (34'(yw_s1) - 34'(xz_s1)) <<< 1;
		hd = ONE_Q28 - ((34'(yy_s1) + 34'(zz_s1)) <<< 1);
		bn = (34'(xw_s1) - 34'(yz_s1)) <<< 1;
		bd = ONE_Q28 - ((34'(xx_s1) + 34'(zz_s1)) <<< 1);
		priority if (test > POLE_LIMIT) pole_c = POLE_NORTH;
		else if (test < -POLE_LIMIT) pole_c = POLE_SOUTH;
		else pole_c = POLE_NONE;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pole_s2 <= pole_c;
			if (pole_c != POLE_NONE) begin
				hy_s2 <= CW'(x_s1);
				hx_s2 <= CW'(w_s1);
			end else begin
				hy_s2 <= CW'(hn);
				hx_s2 <= CW'(hd);
			end
			by_s2 <= CW'(bn);
			bx_s2 <= CW'(bd);
			if (s_full > 35'sd268435456) s_s2 <= 30'sd268435456;
			else if (s_full < -35'sd268435456) s_s2 <= -30'sd268435456;
			else s_s2 <= 30'(s_full);
		end
	end

	// stage 3: radicand 1 - s^2 in Q.56, heading and bank quadrant fold
	assign ssq = s_s2 * s_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3 <= (SW'(1) << 56) - ssq[SW-1:0];
			ch[0] <= cordic_pre(hy_s2, hx_s2);
			cb[0] <= cordic_pre(by_s2, bx_s2);
			side_q[0] <= '{pole: pole_s2,
				zero_h: (hy_s2 == '0) && (hx_s2 == '0),
				zero_b: (by_s2 == '0) && (bx_s2 == '0)};
			sdel_q[0] <= s_s2;
		end
	end

	// square root cells
	assign sq[0] = '{v: rad_s3, r: '0};

	for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
		qe_sqrt_cell u_cell (
			.clk  (clk),
			.adv  (adv),
			.k    (5'(SQRT_CELLS - 1 - g)),
			.din  (sq[g]),
			.dout (sq[g+1])
		);
	end

	// heading and bank CORDIC rows
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_hb
		qe_cordic_cell u_head (
			.clk  (clk),
			.adv  (adv),
			.idx  (5'(g)),
			.din  (ch[g]),
			.dout (ch[g+1])
		);
		qe_cordic_cell u_bank (
			.clk  (clk),
			.adv  (adv),
			.idx  (5'(g)),
			.din  (cb[g]),
			.dout (cb[g+1])
		);
	end

	// arcsine row: atan2(s, sqrt(1 - s^2))
	always_ff @(posedge clk) begin
		if (adv) ca[0] <= cordic_pre(CW'(sdel_q[HOLD_LEN-1]), CW'(sq[SQRT_CELLS].r[28:0]));
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_att
		qe_cordic_cell u_att (
			.clk  (clk),
			.adv  (adv),
			.idx  (5'(g)),
			.din  (ca[g]),
			.dout (ca[g+1])
		);
	end

	// delay lines to line up with the arcsine row
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 1; i < SIDE_LEN; i++) side_q[i] <= side_q[i-1];
			for (int i = 1; i < HOLD_LEN; i++) sdel_q[i] <= sdel_q[i-1];
			zh_q[0] <= ch[CORDIC_STAGES].z;
			zb_q[0] <= cb[CORDIC_STAGES].z;
			for (int i = 1; i < HOLD_LEN; i++) begin
				zh_q[i] <= zh_q[i-1];
				zb_q[i] <= zb_q[i-1];
			end
		end
	end

	// final scaling and pole overrides
	always_comb begin
		side_o = side_q[SIDE_LEN-1];
		zh_o = side_o.zero_h ? '0 : zh_q[HOLD_LEN-1];
		zb_o = side_o.zero_b ? '0 : zb_q[HOLD_LEN-1];
		hv = 31'(zh_o) <<< 1;
		att_c = to_q13(31'(ca[CORDIC_STAGES].z), HALF_PI_Q13);
		bank_c = to_q13(31'(zb_o), LIM_REG);
		unique case (side_o.pole)
			POLE_NORTH: begin
				head_c = to_q13(hv, LIM_POLE);
				att_c = HALF_PI_Q13;
				bank_c = '0;
			end
			POLE_SOUTH: begin
				head_c = to_q13(-hv, LIM_POLE);
				att_c = -HALF_PI_Q13;
				bank_c = '0;
			end
			default: head_c = to_q13(31'(zh_o), LIM_REG);
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			heading <= head_c;
			attitude <= att_c[14:0];
			bank <= bank_c[15:0];
			pole_case <= side_o.pole;
		end
	end

endmodule

// ===== rtl/qe_sqrt_cell.sv =====
module qe_sqrt_cell
	import qe_pkg::*;
(
	input  logic       clk,
	input  logic       adv,
	input  logic [4:0] k,
	input  sqrt_t      din,
	output sqrt_t      dout
);

	logic [SW-1:0] b;
	logic [SW-1:0] rb;
	sqrt_t         nxt;

	// one result bit per cell: trial subtract of r + 4^k
	always_comb begin
		b = SW'(1) << {k, 1'b0};
		rb = din.r + b;
		if (din.v >= rb) begin
			nxt.v = din.v - rb;
			nxt.r = (din.r >> 1) + b;
		end else begin
			nxt.v = din.v;
			nxt.r = din.r >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) dout <= nxt;
	end

endmodule

// ===== rtl/qe_cordic_cell.sv =====
module qe_cordic_cell
	import qe_pkg::*;
(
	input  logic       clk,
	input  logic       adv,
	input  logic [4:0] idx,
	input  cordic_t    din,
	output cordic_t    dout
);

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	logic signed [ZW-1:0] a;
	cordic_t              nxt;

	// one vectoring rotation toward the x axis
	always_comb begin
		dx = din.y >>> idx;
		dy = din.x >>> idx;
		a = atan_val(idx);
		if (din.y > 0) begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.z = din.z + a;
		end else begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.z = din.z - a;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) dout <= nxt;
	end

endmodule

// ===== rtl/qe_checker.sv =====
module qe_checker
	import qe_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [16:0] heading,
	input logic signed [14:0] attitude,
	input logic [1:0]         pole_case
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(heading) && $stable(pole_case))
		else $error("stalled result changed");

	// an empty output register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// north pole results carry the fixed attitude
	a_pole: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pole_case == POLE_NORTH |-> attitude == 15'sd12868)
		else $error("north pole attitude wrong");

	// every attitude stays within half pi and the pole code is valid
	a_att: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> attitude <= 15'sd12868 && attitude >= -15'sd12868
			&& (pole_case == POLE_NONE || pole_case == POLE_NORTH
			|| pole_case == POLE_SOUTH))
		else $error("attitude or pole code out of range");

endmodule

bind quaternion_to_euler_angles qe_checker u_qe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.heading   (heading),
	.attitude  (attitude),
	.pole_case (pole_case)
);

// ===== verif/quaternion_to_euler_angles_tb.sv =====
module quaternion_to_euler_angles_tb;
	import qe_pkg::*;

	localparam int ARCTAN_ROWS   = 24;
	localparam int PIPE_LATENCY  = 34 + CORDIC_STAGES;
	localparam int STALL_LIMIT   = 20000;
	localparam longint Q28_ONE   = 64'sd268435456;
	localparam longint POLE_EDGE = 64'sd133949292;
	localparam longint PI_Q24_L  = 64'sd52707179;

	typedef struct {
		logic signed [16:0] heading;
		logic signed [14:0] attitude;
		logic signed [15:0] bank;
		pole_t              pole;
	} angles_t;

	// floor shift of a signed value
	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint arctan_row(int i);
		longint rows [ARCTAN_ROWS] = '{13176795, 7778716, 4110060, 2086331, 1047214,
			524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
			512, 256, 128, 64, 32, 16, 8, 4, 2};
		return rows[i];
	endfunction

	// vectoring arctangent in Q.24 radians
	function automatic longint vec_atan2(longint yv, longint xv);
		longint ang;
		longint dx;
		longint dy;
		ang = 0;
		if (xv == 0 && yv == 0) return 0;
		if (xv < 0) begin
			ang = (yv >= 0) ? PI_Q24_L : -PI_Q24_L;
			xv = -xv;
			yv = -yv;
		end
		for (int i = 0; i < CORDIC_STAGES && i < ARCTAN_ROWS; i++) begin
			dx = shr_floor(yv, i);
			dy = shr_floor(xv, i);
			if (yv > 0) begin
				xv += dx;
				yv -= dy;
				ang += arctan_row(i);
			end else begin
				xv -= dx;
				yv += dy;
				ang -= arctan_row(i);
			end
		end
		return ang;
	endfunction

	function automatic longint root_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint rad_q13(longint q24, longint lim);
		longint r;
		r = shr_floor(q24 + 1024, 11);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic angles_t euler_of(logic signed [15:0] qw, logic signed [15:0] qx,
			logic signed [15:0] qy, logic signed [15:0] qz);
		angles_t a;
		longint w, x, y, z, tst, s, c;
		w = qw; x = qx; y = qy; z = qz;
		tst = x * y + z * w;
		if (tst > POLE_EDGE) begin
			a.heading = 17'(rad_q13(2 * vec_atan2(x, w), 51472));
			a.attitude = 15'(12868);
			a.bank = '0;
			a.pole = POLE_NORTH;
		end else if (tst < -POLE_EDGE) begin
			a.heading = 17'(rad_q13(-2 * vec_atan2(x, w), 51472));
			a.attitude = -15'sd12868;
			a.bank = '0;
			a.pole = POLE_SOUTH;
		end else begin
			s = 2 * tst;
			if (s > Q28_ONE) s = Q28_ONE;
			if (s < -Q28_ONE) s = -Q28_ONE;
			c = root_floor((64'd1 << 56) - longint'(s * s));
			a.heading = 17'(rad_q13(vec_atan2(2 * (y * w - x * z),
				Q28_ONE - 2 * (y * y + z * z)), 25736));
			a.attitude = 15'(rad_q13(vec_atan2(s, c), 12868));
			a.bank = 16'(rad_q13(vec_atan2(2 * (x * w - y * z),
				Q28_ONE - 2 * (x * x + z * z)), 25736));
			a.pole = POLE_NONE;
		end
		return a;
	endfunction

	class angle_board;
		angles_t pending[$];
		int      errors;

		function void note_quat(logic signed [15:0] qw, logic signed [15:0] qx,
				logic signed [15:0] qy, logic signed [15:0] qz);
			pending = {pending, euler_of(qw, qx, qy, qz)};
		endfunction

		function void check_angles(angles_t got);
			angles_t want;
			if (pending.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.heading !== want.heading) begin
				$error("heading expected %0d actual %0d", want.heading, got.heading);
				errors++;
			end
			if (got.attitude !== want.attitude) begin
				$error("attitude expected %0d actual %0d", want.attitude, got.attitude);
				errors++;
			end
			if (got.bank !== want.bank) begin
				$error("bank expected %0d actual %0d", want.bank, got.bank);
				errors++;
			end
			if (got.pole !== want.pole) begin
				$error("pole_case expected %0d actual %0d", want.pole, got.pole);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic signed [15:0] quat_w = 0, quat_x = 0, quat_y = 0, quat_z = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [16:0] heading;
	logic signed [14:0] attitude;
	logic signed [15:0] bank;
	logic [1:0]         pole_case;

	angle_board board = new();
	int send_idle_pct;
	int sink_stall_pct;
	int quiet_cycles;

	quaternion_to_euler_angles dut (.*);

	always #6 clk = ~clk;

	// check each result transfer, randomize receiver stalls
	always @(posedge clk) begin
		angles_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.heading = heading;
				got.attitude = attitude;
				got.bank = bank;
				got.pole = pole_t'(pole_case);
				board.check_angles(got);
			end
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// count cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// drive one quaternion and hold it until the transfer
	task automatic send_quat(int qw, int qx, int qy, int qz);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		quat_w <= 16'(qw); quat_x <= 16'(qx); quat_y <= 16'(qy); quat_z <= 16'(qz);
		do @(posedge clk); while (!in_ready);
		board.note_quat(16'(qw), 16'(qx), 16'(qy), 16'(qz));
	endtask

	function automatic logic signed [15:0] rand_comp(int span);
		return 16'($signed($urandom_range(2 * span)) - span);
	endfunction

	// mostly near-unit quaternions, some near the poles, some raw bits
	task automatic send_random();
		int kind;
		int w, x, y, z;
		longint n;
		kind = $urandom_range(9);
		if (kind < 6) begin
			w = rand_comp(16384); x = rand_comp(16384);
			y = rand_comp(16384); z = rand_comp(16384);
			n = longint'(w) * w + longint'(x) * x + longint'(y) * y + longint'(z) * z;
			if (n > 0) begin
				n = root_floor(n);
				w = int'(w * 16384 / n); x = int'(x * 16384 / n);
				y = int'(y * 16384 / n); z = int'(z * 16384 / n);
			end
			send_quat(w, x, y, z);
		end else if (kind < 8) begin
			// x near y and z near w gives test near x*x + w*w, negated when y and z flip
			w = rand_comp(11585); x = rand_comp(11585);
			y = x + rand_comp(300); z = w + rand_comp(300);
			if (kind == 7) begin
				y = -y;
				z = -z;
			end
			send_quat(w, x, y, z);
		end else begin
			send_quat($urandom, $urandom, $urandom, $urandom);
		end
	endtask

	// drop valid and wait for every pending result
	task automatic drain();
		in_valid <= 0;
		do @(posedge clk); while (board.pending.size() != 0);
	endtask

	initial begin
		int phase_idle [4] = '{0, 80, 0, 37};
		int phase_stall [4] = '{0, 0, 80, 37};
		send_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, poles, zero, non-unit
		send_quat(16384, 0, 0, 0);
		send_quat(-16384, 0, 0, 0);
		send_quat(0, 0, 0, 0);
		send_quat(0, 16384, 0, 0);
		send_quat(0, 0, 16384, 0);
		send_quat(0, 0, 0, 16384);
		send_quat(0, -16384, 0, 0);
		send_quat(11585, 0, 0, 11585);
		send_quat(11585, 0, 0, -11585);
		send_quat(8192, 8192, 8192, 8192);
		send_quat(8192, -8192, -8192, 8192);
		send_quat(-8192, 8192, -8192, 8192);
		send_quat(-8192, -8192, 8192, 8192);
		send_quat(16384, 16384, 16384, 16384);
		send_quat(-16384, -16384, 16384, 16384);
		send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_quat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
		send_quat(-1, -1, -1, -1);
		send_quat(11570, 11570, 11570, 0);
		send_quat(0, 11585, 11585, 0);
		send_quat(0, -11585, 11585, 0);
		send_quat(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
		// hold off until the pipeline is empty
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_idle[p];
			sink_stall_pct = phase_stall[p];
			repeat (360) send_random();
			if (p == 1) drain();
		end
		send_idle_pct = 0;
		sink_stall_pct = 0;
		drain();
		repeat (PIPE_LATENCY + 10) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
